// File: hw/rtl/rpmt_pkg.sv
// ----------------------------------------------------------------------------
// rpmt_pkg
// Types and constants shared by the range product tree modules.
// ----------------------------------------------------------------------------
package rpmt_pkg;

    localparam int unsigned LEAVES_DEF = 1024;
    localparam int unsigned NODE_W     = 31;

    localparam logic [29:0] PRIME     = 30'd1000000007;
    localparam logic [30:0] ZERO_MARK = 31'h4000_0000;
    localparam logic [30:0] NODE_ONE  = 31'd1;

    // floor(2^60 / PRIME), Barrett reciprocal
    localparam logic [63:0] BARRETT_WIDE = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_M    = BARRETT_WIDE[30:0];

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  index;
        logic [9:0]  right_index;
        logic [29:0] value;
    } rpmt_in_t;

    typedef struct packed {
        logic [29:0] product;
        logic        bad_range;
    } rpmt_out_t;

    typedef struct packed {
        logic        start;
        logic [29:0] a;
        logic [29:0] b;
    } mm_req_t;

    typedef struct packed {
        logic        done;
        logic [29:0] res;
    } mm_rsp_t;

endpackage

// File: hw/rtl/rpmt_ram.sv
// ----------------------------------------------------------------------------
// rpmt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpmt_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/rpmt_modmul.sv
// ----------------------------------------------------------------------------
// rpmt_modmul
// Modular multiplier: a*b mod PRIME with one shared 32x32 multiplier,
// Barrett quotient estimate and a subtract-until-reduced correction.
// ----------------------------------------------------------------------------
module rpmt_modmul
    import rpmt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_Q,
        MM_R,
        MM_FIX
    } mm_state_t;

    mm_state_t   state_reg;
    logic [59:0] p_reg;
    logic [30:0] q_reg;
    logic [31:0] r_reg;
    logic        done_reg;
    logic [29:0] res_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb begin
        unique case (state_reg)
            MM_IDLE: begin
                op_x = {2'b00, req.a};
                op_y = {2'b00, req.b};
            end
            MM_Q: begin
                op_x = {1'b0, p_reg[59:29]};
                op_y = {1'b0, BARRETT_M};
            end
            MM_R: begin
                op_x = {1'b0, q_reg};
                op_y = {2'b00, PRIME};
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign prod = op_x * op_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MM_IDLE: begin
                    if (req.start) begin
                        p_reg     <= prod[59:0];
                        state_reg <= MM_Q;
                    end
                end
                MM_Q: begin
                    q_reg     <= prod[61:31];
                    state_reg <= MM_R;
                end
                MM_R: begin
                    // estimate is short by at most 3, so r < 4*PRIME fits 32 bits
                    r_reg     <= p_reg[31:0] - prod[31:0];
                    state_reg <= MM_FIX;
                end
                MM_FIX: begin
                    if (r_reg >= {2'b00, PRIME}) begin
                        r_reg <= r_reg - {2'b00, PRIME};
                    end else begin
                        res_reg   <= r_reg[29:0];
                        done_reg  <= 1'b1;
                        state_reg <= MM_IDLE;
                    end
                end
                default: state_reg <= MM_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// File: hw/rtl/range_product_mod_tree.sv
// ----------------------------------------------------------------------------
// range_product_mod_tree
// Segment tree of residues mod 1000000007 with point write and range product.
// ----------------------------------------------------------------------------
// The tree sits in one node RAM of 2*LEAVES entries. After reset a clearing
// pass marks every node zero; no item is taken meanwhile (configuration
// writes are). A write item walks from the leaf to the root, one level per
// step: read the sibling, multiply, write the parent. Each modular multiply
// runs on one shared 32x32 multiplier; a zero operand skips the multiply. A
// query visits at most two nodes per level, plus one shift step per level;
// a bad range goes straight to the output without visiting any node. One
// item is in work at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module range_product_mod_tree
    import rpmt_pkg::*;
#(
    parameter int unsigned LEAVES = LEAVES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rpmt_in_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output rpmt_out_t  m_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int unsigned DEPTH = 2 * LEAVES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned LW1   = $clog2(LEAVES) + 1;
    localparam int unsigned SW    = (LW1 > 11) ? LW1 : 11;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_UP,
        ST_W_RD,
        ST_W_MUL,
        ST_W_WR,
        ST_Q_STEP,
        ST_Q_RD,
        ST_Q_MUL,
        ST_Q_OUT
    } state_t;

    state_t      state_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] pos_reg;
    logic [AW:0]   lo_reg;
    logic [AW:0]   hi_reg;
    logic [30:0]   cur_reg;
    logic          bad_reg;
    logic [SW-1:0] size_reg;
    logic          m_valid_reg;
    rpmt_out_t     m_item_reg;

    logic [SW-1:0] used_size;
    logic          in_fire;
    logic          wr_ok;
    logic          q_bad;
    logic [29:0]   val_red;
    logic [30:0]   leaf_val;
    logic [AW-1:0] leaf_pos;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [30:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [30:0]   ram_rdata;

    mm_req_t       mm_req;
    mm_rsp_t       mm_rsp;
    logic          rd_zero;

    assign used_size = (size_reg > SW'(LEAVES)) ? SW'(LEAVES) : size_reg;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign wr_ok    = SW'(s_item.index) < used_size;
    assign q_bad    = (SW'(s_item.right_index) >= used_size)
                   || (s_item.index > s_item.right_index);
    assign val_red  = (s_item.value >= PRIME) ? (s_item.value - PRIME) : s_item.value;
    assign leaf_val = (val_red == '0) ? ZERO_MARK : {1'b0, val_red};
    assign leaf_pos = AW'(s_item.index) + AW'(LEAVES);

    assign rd_zero  = ram_rdata[30] || cur_reg[30];

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = cur_reg;
        ram_raddr = pos_reg ^ AW'(1);
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = ZERO_MARK;
            end
            ST_IDLE: begin
                ram_we    = in_fire && (s_item.kind == KIND_WRITE) && wr_ok;
                ram_waddr = leaf_pos;
                ram_wdata = leaf_val;
            end
            ST_W_WR: ram_we = 1'b1;
            ST_Q_STEP: begin
                ram_raddr = lo_reg[0] ? lo_reg[AW-1:0] : (hi_reg[AW-1:0] - AW'(1));
            end
            default: ;
        endcase
    end

    always_comb begin
        mm_req.start = ((state_reg == ST_W_RD) || (state_reg == ST_Q_RD)) && !rd_zero;
        mm_req.a     = cur_reg[29:0];
        mm_req.b     = ram_rdata[29:0];
    end

    rpmt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpmt_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            size_reg    <= SW'(LEAVES);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg <= SW'(cfg_data);
            end
            // in ST_Q_OUT the output register is handled below
            if (m_valid_reg && m_ready && (state_reg != ST_Q_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_item.kind == KIND_WRITE) begin
                            if (wr_ok) begin
                                pos_reg   <= leaf_pos;
                                cur_reg   <= leaf_val;
                                state_reg <= ST_W_UP;
                            end
                        end else begin
                            bad_reg   <= q_bad;
                            cur_reg   <= NODE_ONE;
                            lo_reg    <= (AW+1)'(s_item.index) + (AW+1)'(LEAVES);
                            hi_reg    <= (AW+1)'(s_item.right_index)
                                       + (AW+1)'(LEAVES) + (AW+1)'(1);
                            state_reg <= q_bad ? ST_Q_OUT : ST_Q_STEP;
                        end
                    end
                end
                ST_W_UP: begin
                    if (pos_reg == AW'(1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        pos_reg   <= pos_reg >> 1;
                        state_reg <= ST_W_RD;
                    end
                end
                ST_W_RD: begin
                    if (rd_zero) begin
                        cur_reg   <= ZERO_MARK;
                        state_reg <= ST_W_WR;
                    end else begin
                        state_reg <= ST_W_MUL;
                    end
                end
                ST_W_MUL: begin
                    if (mm_rsp.done) begin
                        cur_reg   <= {1'b0, mm_rsp.res};
                        state_reg <= ST_W_WR;
                    end
                end
                ST_W_WR: state_reg <= ST_W_UP;
                ST_Q_STEP: begin
                    if (lo_reg >= hi_reg) begin
                        state_reg <= ST_Q_OUT;
                    end else if (lo_reg[0]) begin
                        lo_reg    <= lo_reg + (AW+1)'(1);
                        state_reg <= ST_Q_RD;
                    end else if (hi_reg[0]) begin
                        hi_reg    <= hi_reg - (AW+1)'(1);
                        state_reg <= ST_Q_RD;
                    end else begin
                        lo_reg <= lo_reg >> 1;
                        hi_reg <= hi_reg >> 1;
                    end
                end
                ST_Q_RD: begin
                    if (rd_zero) begin
                        cur_reg   <= ZERO_MARK;
                        state_reg <= ST_Q_STEP;
                    end else begin
                        state_reg <= ST_Q_MUL;
                    end
                end
                ST_Q_MUL: begin
                    if (mm_rsp.done) begin
                        cur_reg   <= {1'b0, mm_rsp.res};
                        state_reg <= ST_Q_STEP;
                    end
                end
                ST_Q_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_item_reg.bad_range <= bad_reg;
                        m_item_reg.product   <= (bad_reg || cur_reg[30]) ? '0 : cur_reg[29:0];
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_bad_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.bad_range |-> m_item.product == '0)
        else $error("bad range item with nonzero product");

    a_product_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.bad_range |-> m_item.product < PRIME)
        else $error("product not reduced");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.kind == KIND_WRITE |=> !$rose(m_valid))
        else $error("write item produced a result");

    a_mul_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_rsp.done |-> state_reg == ST_W_MUL || state_reg == ST_Q_MUL)
        else $error("multiplier finished outside a multiply step");

endmodule
